@@ hdl/plt_pkg.sv @@
package plt_pkg;

    // Request kinds
    localparam logic KIND_SET     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Lock kinds; every other code is invalid
    localparam logic [1:0] LK_READ  = 2'd0;
    localparam logic [1:0] LK_WRITE = 2'd1;

    // Result status codes
    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_INVALID    = 3'd2;
    localparam logic [2:0] ST_WOULDBLOCK = 3'd3;
    localparam logic [2:0] ST_WAIT       = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_RELEASED   = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the request on an input transfer
        logic scan_step;  // advance the table scan by one entry
        logic commit;     // insert or mark after the scan
        logic emit;       // load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pre_reject; // request answered without a scan
        logic scan_done;  // last entry checked this cycle
    } sts_t;

endpackage

@@ hdl/plt_ctrl.sv @@
module plt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  plt_pkg::sts_t sts,
    output plt_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE   = 4'b0001,
        SCAN   = 4'b0010,
        COMMIT = 4'b0100,
        RESP   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.pre_reject ? RESP : SCAN;
                end
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = COMMIT;
                end
            end
            COMMIT: begin
                cmd.commit = 1'b1;
                state_next = RESP;
            end
            RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != IDLE))
        else $error("controller stayed idle after an input transfer");
`endif

endmodule

@@ hdl/plt_datapath.sv @@
module plt_datapath #(
    parameter int TABLE_DEPTH = 16,
    parameter int TRANS_BITS  = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  plt_pkg::cmd_t cmd,
    output plt_pkg::sts_t sts,
    input  logic          s_kind,
    input  logic [7:0]    s_trans_id,
    input  logic          s_trans_done,
    input  logic [31:0]   s_position,
    input  logic [7:0]    s_span,
    input  logic [1:0]    s_lock_kind,
    input  logic          s_wait_ok,
    output logic [2:0]    m_status,
    output logic          m_wake_needed,
    output logic          m_any_read,
    output logic          m_any_write
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = TRANS_BITS + 32;

    // Request
    logic                  kind_reg;
    logic [TRANS_BITS-1:0] owner_reg;
    logic [31:0]           pos_reg;
    logic                  req_write_reg;
    logic                  wait_ok_reg;
    logic [23:0]           tid_ext;
    logic                  kind_bad;

    // Table: owner and position in memory, flags in flops
    logic [ENT_W-1:0]       mem [TABLE_DEPTH];
    logic [ENT_W-1:0]       rdata_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] write_reg;
    logic [TABLE_DEPTH-1:0] wanted_reg;
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic [CNT_W-1:0]       wr_cnt_reg;

    // Scan
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             chk_vld_reg;
    logic             check_en;
    logic             e_valid;
    logic             e_write;
    logic             e_wanted;
    logic [TRANS_BITS-1:0] e_owner;
    logic [31:0]      e_pos;
    logic             hit_conf;
    logic             hit_free;
    logic             hit_release;

    logic             conf_found_reg;
    logic [IDX_W-1:0] conf_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             wake_reg;
    logic [2:0]       res_status_reg;
    logic             do_insert;

    assign tid_ext  = {16'b0, s_trans_id};
    assign kind_bad = (s_lock_kind != plt_pkg::LK_READ) && (s_lock_kind != plt_pkg::LK_WRITE);

    assign sts.pre_reject = (s_kind == plt_pkg::KIND_SET) &&
                            (s_trans_done || (s_span != 8'd1) || kind_bad);
    assign sts.scan_done  = chk_vld_reg && (chk_idx_reg == IDX_W'(TABLE_DEPTH - 1));

    assign check_en    = chk_vld_reg && cmd.scan_step;
    assign e_valid     = valid_reg[chk_idx_reg];
    assign e_write     = write_reg[chk_idx_reg];
    assign e_wanted    = wanted_reg[chk_idx_reg];
    assign e_owner     = rdata_reg[ENT_W-1:32];
    assign e_pos       = rdata_reg[31:0];
    assign hit_conf    = check_en && (kind_reg == plt_pkg::KIND_SET) && e_valid &&
                         (e_pos == pos_reg) && (req_write_reg || e_write);
    assign hit_free    = check_en && (kind_reg == plt_pkg::KIND_SET) && !e_valid;
    assign hit_release = check_en && (kind_reg == plt_pkg::KIND_RELEASE) && e_valid &&
                         (e_owner == owner_reg);
    assign do_insert   = cmd.commit && (kind_reg == plt_pkg::KIND_SET) &&
                         !conf_found_reg && free_found_reg;

    // Request capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg       <= s_kind;
            owner_reg      <= tid_ext[TRANS_BITS-1:0];
            pos_reg        <= s_position;
            req_write_reg  <= (s_lock_kind == plt_pkg::LK_WRITE);
            wait_ok_reg    <= s_wait_ok;
            rd_idx_reg     <= '0;
            conf_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            wake_reg       <= 1'b0;
            if (s_kind == plt_pkg::KIND_RELEASE) begin
                res_status_reg <= plt_pkg::ST_RELEASED;
            end else if (s_trans_done) begin
                res_status_reg <= plt_pkg::ST_DONE;
            end else begin
                res_status_reg <= plt_pkg::ST_INVALID;
            end
        end else begin
            if (cmd.scan_step) begin
                if (rd_idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    rd_idx_reg <= '0;
                end else begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
            end
            // keep only the lowest conflicting and lowest free entry
            if (hit_conf && !conf_found_reg) begin
                conf_found_reg <= 1'b1;
                conf_idx_reg   <= chk_idx_reg;
            end
            if (hit_free && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= chk_idx_reg;
            end
            if (hit_release && e_wanted) begin
                wake_reg <= 1'b1;
            end
            if (cmd.commit && (kind_reg == plt_pkg::KIND_SET)) begin
                if (conf_found_reg) begin
                    res_status_reg <= wait_ok_reg ? plt_pkg::ST_WAIT : plt_pkg::ST_WOULDBLOCK;
                end else if (!free_found_reg) begin
                    res_status_reg <= plt_pkg::ST_FULL;
                end else begin
                    res_status_reg <= plt_pkg::ST_GRANTED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_vld_reg <= 1'b0;
        end else if (cmd.load) begin
            chk_vld_reg <= 1'b0;
        end else begin
            chk_vld_reg <= cmd.scan_step;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            mem[free_idx_reg] <= {owner_reg, pos_reg};
        end
        rdata_reg   <= mem[rd_idx_reg];
        chk_idx_reg <= rd_idx_reg;
    end

    // Entry flags and lock counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            wanted_reg <= '0;
            rd_cnt_reg <= '0;
            wr_cnt_reg <= '0;
        end else begin
            if (hit_release) begin
                valid_reg[chk_idx_reg]  <= 1'b0;
                wanted_reg[chk_idx_reg] <= 1'b0;
                if (e_write) begin
                    wr_cnt_reg <= wr_cnt_reg - CNT_W'(1);
                end else begin
                    rd_cnt_reg <= rd_cnt_reg - CNT_W'(1);
                end
            end
            if (cmd.commit && (kind_reg == plt_pkg::KIND_SET) && conf_found_reg &&
                wait_ok_reg) begin
                wanted_reg[conf_idx_reg] <= 1'b1;
            end
            if (do_insert) begin
                valid_reg[free_idx_reg]  <= 1'b1;
                wanted_reg[free_idx_reg] <= 1'b0;
                if (req_write_reg) begin
                    wr_cnt_reg <= wr_cnt_reg + CNT_W'(1);
                end else begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_insert) begin
            write_reg[free_idx_reg] <= req_write_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status      <= res_status_reg;
            m_wake_needed <= wake_reg;
            m_any_read    <= (rd_cnt_reg != '0);
            m_any_write   <= (wr_cnt_reg != '0);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, rd_cnt_reg} + {1'b0, wr_cnt_reg}) <= (CNT_W + 1)'(TABLE_DEPTH))
        else $error("held lock count exceeds table depth");

    a_conflict_no_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && conf_found_reg) |=> ($stable(rd_cnt_reg) && $stable(wr_cnt_reg)))
        else $error("lock inserted despite a conflict");
`endif

endmodule

@@ hdl/position_lock_table.sv @@
// A set request rejected on its own fields skips the scan; any other request is
//   answered after a scan of the whole table and a commit step.
// A request is taken only after the last result is loaded; the pace is set by the
//   scan, reading one entry per cycle from the entry memory's single read port.
// Reset (aresetn low, synchronous): all entries invalid, counts zero, no result held.
module position_lock_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int TRANS_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_trans_id,
    input  logic        s_trans_done,
    input  logic [31:0] s_position,
    input  logic [7:0]  s_span,
    input  logic [1:0]  s_lock_kind,
    input  logic        s_wait_ok,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_wake_needed,
    output logic        m_any_read,
    output logic        m_any_write
);

    // Commands flow controller to datapath; status flows back.
    plt_pkg::cmd_t cmd;
    plt_pkg::sts_t sts;

    // Controller: accept a transfer, scan and commit unless its fields reject it,
    // then hold the result until the result channel takes the transfer.
    plt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: lock table, scan compare, insert/mark/release, lock counts
    // that feed the any-read and any-write flags, and the result register.
    plt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TRANS_BITS  (TRANS_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_kind        (s_kind),
        .s_trans_id    (s_trans_id),
        .s_trans_done  (s_trans_done),
        .s_position    (s_position),
        .s_span        (s_span),
        .s_lock_kind   (s_lock_kind),
        .s_wait_ok     (s_wait_ok),
        .m_status      (m_status),
        .m_wake_needed (m_wake_needed),
        .m_any_read    (m_any_read),
        .m_any_write   (m_any_write)
    );

endmodule

@@ bench/lock_table_checker.sv @@
module lock_table_checker #(
    parameter int DEPTH      = 16,
    parameter int OWNER_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_trans_id,
    input  logic        s_trans_done,
    input  logic [31:0] s_position,
    input  logic [7:0]  s_span,
    input  logic [1:0]  s_lock_kind,
    input  logic        s_wait_ok,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic        m_wake_needed,
    input  logic        m_any_read,
    input  logic        m_any_write,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic                  valid;
        logic [OWNER_BITS-1:0] owner;
        logic [31:0]           pos;
        logic                  is_write;
        logic                  wanted;
    } lock_slot_t;

    typedef struct packed {
        logic [2:0] status;
        logic       wake;
        logic       any_read;
        logic       any_write;
    } lock_result_t;

    lock_slot_t   shadow_locks [DEPTH];
    lock_result_t expected_results [$];
    int           err_count   = 0;
    int           outstanding = 0;

    assign mismatches = err_count;
    assign pending    = outstanding;

    // Apply one request to the shadow table and return the answer it earns.
    function automatic lock_result_t predict_lock_result(
        input logic        kind,
        input logic [7:0]  trans_id,
        input logic        trans_done,
        input logic [31:0] position,
        input logic [7:0]  span,
        input logic [1:0]  lock_kind,
        input logic        wait_ok
    );
        lock_result_t          res;
        logic [OWNER_BITS-1:0] owner;
        int                    free_idx;
        int                    i;
        logic                  want_write;
        logic                  hit;
        res      = '0;
        owner    = trans_id[OWNER_BITS-1:0];
        free_idx = -1;
        hit      = 1'b0;
        if (kind == plt_pkg::KIND_RELEASE) begin
            res.status = plt_pkg::ST_RELEASED;
            for (i = 0; i < DEPTH; i++) begin
                if (shadow_locks[i].valid && shadow_locks[i].owner == owner) begin
                    if (shadow_locks[i].wanted)
                        res.wake = 1'b1;
                    shadow_locks[i] = '0;
                end
            end
        end else if (trans_done) begin
            res.status = plt_pkg::ST_DONE;
        end else if (span != 8'd1) begin
            res.status = plt_pkg::ST_INVALID;
        end else if (lock_kind != plt_pkg::LK_READ && lock_kind != plt_pkg::LK_WRITE) begin
            res.status = plt_pkg::ST_INVALID;
        end else begin
            want_write = (lock_kind == plt_pkg::LK_WRITE);
            for (i = 0; i < DEPTH; i++) begin
                if (!hit) begin
                    if (!shadow_locks[i].valid) begin
                        if (free_idx < 0)
                            free_idx = i;
                    end else if (shadow_locks[i].pos == position &&
                                 (want_write || shadow_locks[i].is_write)) begin
                        hit = 1'b1;
                        if (wait_ok) begin
                            shadow_locks[i].wanted = 1'b1;
                            res.status = plt_pkg::ST_WAIT;
                        end else begin
                            res.status = plt_pkg::ST_WOULDBLOCK;
                        end
                    end
                end
            end
            if (!hit) begin
                if (free_idx < 0) begin
                    res.status = plt_pkg::ST_FULL;
                end else begin
                    shadow_locks[free_idx].valid    = 1'b1;
                    shadow_locks[free_idx].owner    = owner;
                    shadow_locks[free_idx].pos      = position;
                    shadow_locks[free_idx].is_write = want_write;
                    shadow_locks[free_idx].wanted   = 1'b0;
                    res.status = plt_pkg::ST_GRANTED;
                end
            end
        end
        for (i = 0; i < DEPTH; i++) begin
            if (shadow_locks[i].valid) begin
                if (shadow_locks[i].is_write)
                    res.any_write = 1'b1;
                else
                    res.any_read = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        lock_result_t want;
        int           i;
        if (!aresetn) begin
            for (i = 0; i < DEPTH; i++)
                shadow_locks[i] = '0;
            expected_results.delete();
        end else begin
            // Retire the result first: it always belongs to an earlier request.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: status %0d", m_status);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        err_count++;
                    end
                    if (m_wake_needed !== want.wake) begin
                        $error("wake_needed: expected %0d, actual %0d",
                               want.wake, m_wake_needed);
                        err_count++;
                    end
                    if (m_any_read !== want.any_read) begin
                        $error("any_read: expected %0d, actual %0d",
                               want.any_read, m_any_read);
                        err_count++;
                    end
                    if (m_any_write !== want.any_write) begin
                        $error("any_write: expected %0d, actual %0d",
                               want.any_write, m_any_write);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_lock_result(
                    s_kind, s_trans_id, s_trans_done, s_position,
                    s_span, s_lock_kind, s_wait_ok));
        end
        outstanding = expected_results.size();
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;

    localparam int DEPTH       = 16;
    localparam int OWNER_BITS  = 8;
    localparam int LATENCY     = DEPTH + 3;
    // Longest correct quiet stretch is the receiver hold-off plus one scan;
    // take it several times over.
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    // Request and lock kind codes
    localparam logic       KIND_SET     = plt_pkg::KIND_SET;
    localparam logic       KIND_RELEASE = plt_pkg::KIND_RELEASE;
    localparam logic [1:0] LK_READ      = plt_pkg::LK_READ;
    localparam logic [1:0] LK_WRITE     = plt_pkg::LK_WRITE;

    // Lock kind codes outside the two legal ones
    localparam logic [1:0] LK_BAD_LOW  = 2'd2;
    localparam logic [1:0] LK_BAD_HIGH = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  trans_id;
        logic        trans_done;
        logic [31:0] position;
        logic [7:0]  span;
        logic [1:0]  lock_kind;
        logic        wait_ok;
    } lock_req_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_kind        = KIND_SET;
    logic [7:0]  s_trans_id    = 8'd0;
    logic        s_trans_done  = 1'b0;
    logic [31:0] s_position    = 32'd0;
    logic [7:0]  s_span        = 8'd1;
    logic [1:0]  s_lock_kind   = LK_READ;
    logic        s_wait_ok     = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_status;
    logic        m_wake_needed;
    logic        m_any_read;
    logic        m_any_write;

    int mismatches;
    int pending;

    // Shared between the stimulus and the result sink
    bit hold_request = 1'b0;
    bit steady_sink  = 1'b0;

    int sent_count    = 0;
    int set_count     = 0;
    int release_count = 0;
    int idle_cycles   = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    position_lock_table #(
        .TABLE_DEPTH (DEPTH),
        .TRANS_BITS  (OWNER_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_trans_id    (s_trans_id),
        .s_trans_done  (s_trans_done),
        .s_position    (s_position),
        .s_span        (s_span),
        .s_lock_kind   (s_lock_kind),
        .s_wait_ok     (s_wait_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_wake_needed (m_wake_needed),
        .m_any_read    (m_any_read),
        .m_any_write   (m_any_write)
    );

    lock_table_checker #(
        .DEPTH      (DEPTH),
        .OWNER_BITS (OWNER_BITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_trans_id    (s_trans_id),
        .s_trans_done  (s_trans_done),
        .s_position    (s_position),
        .s_span        (s_span),
        .s_lock_kind   (s_lock_kind),
        .s_wait_ok     (s_wait_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_wake_needed (m_wake_needed),
        .m_any_read    (m_any_read),
        .m_any_write   (m_any_write),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic lock_req_t req(input logic kind, input logic [7:0] trans_id,
                                      input logic done, input logic [31:0] position,
                                      input logic [7:0] span, input logic [1:0] lock_kind,
                                      input logic wait_ok);
        lock_req_t r;
        r.kind       = kind;
        r.trans_id   = trans_id;
        r.trans_done = done;
        r.position   = position;
        r.span       = span;
        r.lock_kind  = lock_kind;
        r.wait_ok    = wait_ok;
        return r;
    endfunction

    // Build a random request. Most are well-formed sets from a small pool of
    // owners and positions, so that locks collide, fill the table and get
    // released; the rest are releases and requests that fail a field check.
    function automatic lock_req_t make_request(input int hot, input int rel_pct);
        lock_req_t r;
        int        pick;
        int        slot;
        r.kind       = KIND_SET;
        r.trans_id   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 7));
        slot         = $urandom_range(0, hot - 1);
        if (slot == 0)
            r.position = 32'h0000_0000;
        else if (slot == 1)
            r.position = 32'hFFFF_FFFF;
        else
            r.position = 32'(slot) * 32'h0101_0003;
        if ($urandom_range(0, 19) == 0)
            r.position = $urandom();
        r.trans_done = 1'b0;
        r.span       = 8'd1;
        r.lock_kind  = ($urandom_range(0, 1) == 1) ? LK_WRITE : LK_READ;
        r.wait_ok    = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < rel_pct) begin
            // Release ignores every field but the owner; scramble them.
            r.kind       = KIND_RELEASE;
            r.trans_done = 1'($urandom_range(0, 1));
            r.span       = 8'($urandom_range(0, 255));
            r.lock_kind  = 2'($urandom_range(0, 3));
        end else if (pick >= 88) begin
            case ($urandom_range(0, 2))
                0: r.trans_done = 1'b1;
                1: begin
                    r.span = 8'($urandom_range(0, 255));
                    if (r.span == 8'd1)
                        r.span = 8'd0;
                end
                default: r.lock_kind = ($urandom_range(0, 1) == 1) ? LK_BAD_HIGH
                                                                   : LK_BAD_LOW;
            endcase
        end
        return r;
    endfunction

    // Offer one request and hold it until the transfer; then either keep
    // valid high for the next one or drop it for the gap.
    task automatic send_req(input lock_req_t r, input int gap);
        s_valid      <= 1'b1;
        s_kind       <= r.kind;
        s_trans_id   <= r.trans_id;
        s_trans_done <= r.trans_done;
        s_position   <= r.position;
        s_span       <= r.span;
        s_lock_kind  <= r.lock_kind;
        s_wait_ok    <= r.wait_ok;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (r.kind == KIND_RELEASE)
            release_count++;
        else
            set_count++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every expected result has come back,
    // then let the clock run on with no request offered.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic int sender_gap(input bit steady);
        if (steady || $urandom_range(0, 9) < 6)
            return 0;
        return pick_gap();
    endfunction

    // Result sink: random back-pressure, a long hold-off on request, and
    // steady phases with ready held high.
    initial begin
        int gap_left;
        gap_left = 0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                if (gap_left > 0) begin
                    m_ready <= 1'b0;
                    gap_left--;
                end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
                    m_ready <= 1'b0;
                    gap_left = pick_gap() - 1;
                end else begin
                    m_ready <= 1'b1;
                end
                @(posedge aclk);
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        lock_req_t directed [$];
        int        p;
        int        n;
        int        hot;
        int        rel_pct;
        bit        steady;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty release, read sharing, self conflict on write,
        // wait marking twice, every field rejection, extreme owner and
        // position, and releases that must wake a waiter.
        directed.push_back(req(KIND_RELEASE, 8'd0,   1'b0, 32'h0,         8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_SET,     8'd1,   1'b0, 32'h0,         8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_SET,     8'd2,   1'b0, 32'h0,         8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_SET,     8'd1,   1'b0, 32'h0,         8'd1,   LK_WRITE,    1'b0));
        directed.push_back(req(KIND_SET,     8'd3,   1'b0, 32'h0,         8'd1,   LK_WRITE,    1'b1));
        directed.push_back(req(KIND_SET,     8'd3,   1'b0, 32'h0,         8'd1,   LK_WRITE,    1'b1));
        directed.push_back(req(KIND_SET,     8'd4,   1'b1, 32'h5,         8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'h5,         8'd0,   LK_READ,     1'b0));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'h5,         8'd255, LK_WRITE,    1'b1));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'h0,         8'd1,   LK_BAD_LOW,  1'b1));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'h7,         8'd1,   LK_BAD_HIGH, 1'b0));
        directed.push_back(req(KIND_SET,     8'd255, 1'b0, 32'hFFFF_FFFF, 8'd1,   LK_WRITE,    1'b0));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'hFFFF_FFFF, 8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'hFFFF_FFFF, 8'd1,   LK_READ,     1'b1));
        directed.push_back(req(KIND_SET,     8'd4,   1'b0, 32'h0,         8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_RELEASE, 8'd1,   1'b1, 32'h0,         8'd0,   LK_BAD_HIGH, 1'b1));
        directed.push_back(req(KIND_RELEASE, 8'd255, 1'b0, 32'hFFFF_FFFF, 8'd1,   LK_WRITE,    1'b0));
        directed.push_back(req(KIND_RELEASE, 8'd2,   1'b0, 32'h0,         8'd1,   LK_READ,     1'b0));
        directed.push_back(req(KIND_RELEASE, 8'd4,   1'b0, 32'h0,         8'd1,   LK_READ,     1'b0));
        foreach (directed[i])
            send_req(directed[i], sender_gap(1'b0));
        drain();

        // Random phases: vary the position pool (tight pools collide, wide
        // ones fill the table), the release rate and the idling.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin hot = 2;  rel_pct = 20; end
                1: begin hot = 6;  rel_pct = 15; end
                2: begin hot = 24; rel_pct = 10; end
                3: begin hot = 4;  rel_pct = 25; end
                4: begin hot = 40; rel_pct = 12; end
                5: begin hot = 12; rel_pct = 20; end
                default: begin hot = 3; rel_pct = 30; end
            endcase
            steady      = (p == 1 || p == 4);
            steady_sink = steady;
            // Hold off the sink while the source keeps offering back to back,
            // so the block fills up and stalls its input.
            if (p == 2)
                hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_req(make_request(hot, rel_pct),
                         (p == 2 && n < 40) ? 0 : sender_gap(steady));
            drain();
        end
        steady_sink = 1'b0;

        $display("Summary: %0d requests (%0d lock sets, %0d releases): directed cases plus %0d",
                 sent_count, set_count, release_count, PHASES);
        $display("  random phases with position pools of 2 to 40 and a %0d-cycle sink hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/plt_pkg.sv
hdl/plt_ctrl.sv
hdl/plt_datapath.sv
hdl/position_lock_table.sv
bench/lock_table_checker.sv
bench/tb_top.sv
